### sv/dnsqp_pkg.sv
// Package for the DNS query name parser: shared constants, result codes and
// the result record type. No dependencies.
package dnsqp_pkg;

    localparam logic [3:0] HEADER_BYTES = 4'd12;
    localparam logic [8:0] MAX_NAME     = 9'd256;
    localparam logic [7:0] MAX_LABEL    = 8'd63;

    localparam logic [7:0] DOT_CHAR = 8'd46;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_LONG     = 2'd1;
    localparam logic [1:0] ST_EARLY    = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;

    typedef struct packed {
        logic       kind;
        logic [7:0] name_char;
        logic [7:0] query_type;
        logic [1:0] status;
        logic       last;
    } t_result;

endpackage

### sv/dns_query_name_parser_top.sv
// DNS query name parser top level: parses label-encoded query names from a
// byte stream. Depends on dnsqp_pkg.
//
//  Channel   Direction  tdata (low bit up)                      tuser         tlast
//  s_axis    in         packet_byte                             packet_start  packet_end
//  m_axis    out        name_char, query_type, parse_status, 0  result_kind   last_result
//
// Each input byte is parsed combinationally between the input handshake and output register.
// A byte that causes two results (a character plus an early end) blocks input until the second
// result leaves through the overflow stage. With no output stall the block takes one byte per
// cycle, apart from such bytes; a byte's first result is registered and shown the next cycle.
// Reset is synchronous and active low; it returns the parser to idle and empties the output.
module dns_query_name_parser_top #(
    parameter logic [3:0] HEADER_BYTES = dnsqp_pkg::HEADER_BYTES,
    parameter logic [8:0] MAX_NAME     = dnsqp_pkg::MAX_NAME,
    parameter logic [7:0] MAX_LABEL    = dnsqp_pkg::MAX_LABEL
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [dnsqp_pkg::IN_DATA_W-1:0] s_axis_tdata,   // packet_byte
    input  logic                            s_axis_tuser,   // packet_start
    input  logic                            s_axis_tlast,   // packet_end
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [dnsqp_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // name_char, query_type,
                                                             // parse_status, zero fill
    output logic                            m_axis_tuser,   // result_kind
    output logic                            m_axis_tlast    // last_result
);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_LENGTH = 3'd2;
    localparam logic [2:0] PH_LABEL  = 3'd3;
    localparam logic [2:0] PH_SKIP   = 3'd4;
    localparam logic [2:0] PH_TYPE   = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;

    logic [2:0] r_phase,  n_phase;
    logic [3:0] r_hdr,    n_hdr;
    logic [5:0] r_rem,    n_rem;
    logic [8:0] r_nlen,   n_nlen;
    logic       r_seen,   n_seen;
    logic [1:0] r_es,     n_es;

    dnsqp_pkg::t_result r_o, r_x;
    logic               r_o_valid, r_x_valid;

    dnsqp_pkg::t_result c_emit, c_fin, c_first;
    logic               c_emit_v, c_fin_v, c_v0, c_v1;
    logic               w_acc, w_take;
    logic [7:0]         w_byte;

    assign w_byte        = s_axis_tdata;
    assign m_axis_tvalid = r_o_valid;
    assign w_take        = r_o_valid && m_axis_tready;
    assign s_axis_tready = !r_x_valid && (!r_o_valid || m_axis_tready);
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    assign m_axis_tdata = {6'b0, r_o.status, r_o.query_type, r_o.name_char};
    assign m_axis_tuser = r_o.kind;
    assign m_axis_tlast = r_o.last;

    always_comb begin
        logic ovf;
        ovf      = 1'b0;
        n_phase  = r_phase;
        n_hdr    = r_hdr;
        n_rem    = r_rem;
        n_nlen   = r_nlen;
        n_seen   = r_seen;
        n_es     = r_es;
        c_emit_v = 1'b0;
        c_emit   = '0;
        c_fin_v  = 1'b0;
        c_fin    = '{kind: dnsqp_pkg::KIND_DONE, name_char: 8'd0, query_type: 8'd0,
                     status: dnsqp_pkg::ST_EARLY, last: 1'b1};

        if (s_axis_tuser) begin
            n_phase = (HEADER_BYTES != 4'd0) ? PH_HEADER : PH_LENGTH;
            n_hdr   = '0;
            n_rem   = '0;
            n_nlen  = '0;
            n_seen  = 1'b0;
            n_es    = dnsqp_pkg::ST_OK;
        end

        unique case (n_phase)
            PH_HEADER: begin
                n_hdr = n_hdr + 4'd1;
                if (n_hdr >= HEADER_BYTES) begin
                    n_phase = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                if (n_seen) begin
                    c_emit_v = 1'b1;
                    if (n_nlen >= MAX_NAME) begin
                        c_emit  = '{kind: dnsqp_pkg::KIND_DONE, name_char: 8'd0,
                                    query_type: 8'd0, status: dnsqp_pkg::ST_OVERFLOW,
                                    last: 1'b1};
                        n_phase = PH_DONE;
                        ovf     = 1'b1;
                    end else begin
                        c_emit  = '{kind: dnsqp_pkg::KIND_CHAR, name_char: dnsqp_pkg::DOT_CHAR,
                                    query_type: 8'd0, status: dnsqp_pkg::ST_OK, last: 1'b0};
                        n_nlen  = n_nlen + 9'd1;
                    end
                end
                if (!ovf) begin
                    if (w_byte == 8'd0 || w_byte > MAX_LABEL) begin
                        n_es    = (w_byte == 8'd0) ? dnsqp_pkg::ST_OK : dnsqp_pkg::ST_LONG;
                        n_phase = PH_SKIP;
                    end else begin
                        n_rem   = w_byte[5:0];
                        n_seen  = 1'b1;
                        n_phase = PH_LABEL;
                    end
                end
            end
            PH_LABEL: begin
                c_emit_v = 1'b1;
                if (n_nlen >= MAX_NAME) begin
                    c_emit  = '{kind: dnsqp_pkg::KIND_DONE, name_char: 8'd0, query_type: 8'd0,
                                status: dnsqp_pkg::ST_OVERFLOW, last: 1'b1};
                    n_phase = PH_DONE;
                end else begin
                    c_emit = '{kind: dnsqp_pkg::KIND_CHAR, name_char: w_byte,
                               query_type: 8'd0, status: dnsqp_pkg::ST_OK, last: 1'b0};
                    n_nlen = n_nlen + 9'd1;
                    n_rem  = n_rem - 6'd1;
                    if (n_rem == 6'd0) begin
                        n_phase = PH_LENGTH;
                    end
                end
            end
            PH_SKIP: begin
                n_phase = PH_TYPE;
            end
            PH_TYPE: begin
                c_emit_v = 1'b1;
                c_emit   = '{kind: dnsqp_pkg::KIND_DONE, name_char: 8'd0, query_type: w_byte,
                             status: n_es, last: 1'b1};
                n_phase  = PH_DONE;
            end
            default: begin
            end
        endcase

        if (s_axis_tlast && n_phase != PH_IDLE && n_phase != PH_DONE) begin
            c_fin_v = 1'b1;
            n_phase = PH_DONE;
        end

        c_first = c_emit_v ? c_emit : c_fin;
        c_v0    = c_emit_v || c_fin_v;
        c_v1    = c_emit_v && c_fin_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_hdr     <= '0;
            r_rem     <= '0;
            r_nlen    <= '0;
            r_seen    <= 1'b0;
            r_es      <= dnsqp_pkg::ST_OK;
            r_o_valid <= 1'b0;
            r_x_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_phase <= n_phase;
                r_hdr   <= n_hdr;
                r_rem   <= n_rem;
                r_nlen  <= n_nlen;
                r_seen  <= n_seen;
                r_es    <= n_es;
            end
            if (w_acc && c_v0) begin
                r_o_valid <= 1'b1;
                r_x_valid <= c_v1;
            end else if (w_take) begin
                if (r_x_valid) begin
                    r_x_valid <= 1'b0;
                end else begin
                    r_o_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && c_v0) begin
            r_o <= c_first;
            r_x <= c_fin;
        end else if (w_take && r_x_valid) begin
            r_o <= r_x;
        end
    end

    a_extra_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_x_valid |-> r_o_valid)
        else $error("second result held without a first result");

    a_extra_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_x_valid && !m_axis_tready) |=> r_x_valid)
        else $error("second result dropped during stall");

    a_extra_is_early_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_x_valid |-> (r_x.last && r_x.status == dnsqp_pkg::ST_EARLY))
        else $error("second result is not an early-end finish");

    a_name_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nlen <= MAX_NAME)
        else $error("name length beyond name store");

    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !s_axis_tuser && (r_phase == PH_DONE || r_phase == PH_IDLE)) |=> !r_x_valid)
        else $error("result produced outside a packet");

endmodule

### test/dns_query_name_checker.sv
// Checker for the DNS query name parser: watches both stream channels, parses every
// accepted packet byte itself and compares each output transaction with its own result.
// Depends on dnsqp_pkg.
module dns_query_name_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    input  logic                             i_s_axis_tready,
    input  logic [dnsqp_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,   // packet_byte
    input  logic                             i_s_axis_tuser,   // packet_start
    input  logic                             i_s_axis_tlast,   // packet_end
    input  logic                             i_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    input  logic [dnsqp_pkg::OUT_DATA_W-1:0] i_m_axis_tdata,   // name_char, query_type,
                                                               // parse_status, zero fill
    input  logic                             i_m_axis_tuser,   // result_kind
    input  logic                             i_m_axis_tlast,   // last_result
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_char_count,
    output int                               o_finish_count,
    output logic [3:0]                       o_status_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_LENGTH,
        PH_LABEL,
        PH_SKIP,
        PH_TYPE,
        PH_DONE
    } t_phase;

    t_phase     phase;
    logic [3:0] hdr_count;
    logic [5:0] label_left;
    logic [8:0] name_len;
    logic       label_open;
    logic [1:0] term_status;

    dnsqp_pkg::t_result pending_results[$];
    int                 fail_count;
    int                 char_count;
    int                 finish_count;
    logic [3:0]         status_seen;

    function automatic void clear_parser();
        phase       = PH_IDLE;
        hdr_count   = '0;
        label_left  = '0;
        name_len    = '0;
        label_open  = 1'b0;
        term_status = dnsqp_pkg::ST_OK;
    endfunction

    function automatic void push_result(logic kind, logic [7:0] ch, logic [7:0] qtype,
                                        logic [1:0] status, logic last);
        dnsqp_pkg::t_result r;
        r.kind       = kind;
        r.name_char  = ch;
        r.query_type = qtype;
        r.status     = status;
        r.last       = last;
        pending_results.push_back(r);
    endfunction

    // A character beyond the name store ends the parse with an overflow instead.
    function automatic logic put_name_char(logic [7:0] ch);
        if (name_len >= dnsqp_pkg::MAX_NAME) begin
            push_result(dnsqp_pkg::KIND_DONE, 8'd0, 8'd0, dnsqp_pkg::ST_OVERFLOW, 1'b1);
            phase = PH_DONE;
            return 1'b0;
        end
        push_result(dnsqp_pkg::KIND_CHAR, ch, 8'd0, dnsqp_pkg::ST_OK, 1'b0);
        name_len = name_len + 9'd1;
        return 1'b1;
    endfunction

    function automatic void parse_byte(logic [7:0] b, logic first, logic final_byte);
        if (first) begin
            clear_parser();
            phase = (dnsqp_pkg::HEADER_BYTES > 0) ? PH_HEADER : PH_LENGTH;
        end
        case (phase)
            PH_HEADER: begin
                hdr_count = hdr_count + 4'd1;
                if (hdr_count >= dnsqp_pkg::HEADER_BYTES) begin
                    phase = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                if (!label_open || put_name_char(dnsqp_pkg::DOT_CHAR)) begin
                    if (b == 8'd0 || b > dnsqp_pkg::MAX_LABEL) begin
                        term_status = (b == 8'd0) ? dnsqp_pkg::ST_OK : dnsqp_pkg::ST_LONG;
                        phase       = PH_SKIP;
                    end else begin
                        label_left = b[5:0];
                        label_open = 1'b1;
                        phase      = PH_LABEL;
                    end
                end
            end
            PH_LABEL: begin
                if (put_name_char(b)) begin
                    label_left = label_left - 6'd1;
                    if (label_left == 6'd0) begin
                        phase = PH_LENGTH;
                    end
                end
            end
            PH_SKIP: begin
                phase = PH_TYPE;
            end
            PH_TYPE: begin
                push_result(dnsqp_pkg::KIND_DONE, 8'd0, b, term_status, 1'b1);
                phase = PH_DONE;
            end
            default: begin
            end
        endcase
        if (final_byte && phase != PH_IDLE && phase != PH_DONE) begin
            push_result(dnsqp_pkg::KIND_DONE, 8'd0, 8'd0, dnsqp_pkg::ST_EARLY, 1'b1);
            phase = PH_DONE;
        end
    endfunction

    function automatic void check_field(string field, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, exp_v, act_v);
            fail_count++;
        end
    endfunction

    function automatic void check_result();
        dnsqp_pkg::t_result exp_r;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual kind %0d char 0x%0h",
                     $time, i_m_axis_tuser, i_m_axis_tdata[7:0]);
            fail_count++;
            return;
        end
        exp_r = pending_results.pop_front();
        check_field("result_kind", exp_r.kind, i_m_axis_tuser);
        check_field("name_char", exp_r.name_char, i_m_axis_tdata[7:0]);
        check_field("query_type", exp_r.query_type, i_m_axis_tdata[15:8]);
        check_field("parse_status", exp_r.status, i_m_axis_tdata[17:16]);
        check_field("last_result", exp_r.last, i_m_axis_tlast);
        if (exp_r.kind == dnsqp_pkg::KIND_DONE) begin
            finish_count++;
            status_seen[exp_r.status] = 1'b1;
        end else begin
            char_count++;
        end
    endfunction

    initial begin
        clear_parser();
        fail_count   = 0;
        char_count   = 0;
        finish_count = 0;
        status_seen  = '0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            pending_results.delete();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                check_result();
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                parse_byte(i_s_axis_tdata, i_s_axis_tuser, i_s_axis_tlast);
            end
        end
        o_fail_count   <= fail_count;
        o_pending      <= pending_results.size();
        o_char_count   <= char_count;
        o_finish_count <= finish_count;
        o_status_seen  <= status_seen;
    end

endmodule

### test/tb_dns_query_name_parser_top.sv
// Testbench top for the DNS query name parser: drives packets of header, labels and type
// bytes with random gaps and output stalls, and reports the verdict of the checker.
// Depends on dnsqp_pkg, dns_query_name_parser_top and dns_query_name_checker.
module tb_dns_query_name_parser_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {
        PKT_CLEAN,
        PKT_EARLY_END,
        PKT_ABANDON,
        PKT_OVERFLOW
    } t_pkt_kind;

    typedef struct packed {
        logic [7:0] data;
        logic       pkt_first;
        logic       pkt_end;
    } t_in_byte;

    logic                             i_clk         = 1'b0;
    logic                             i_rst_n       = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [dnsqp_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                             s_axis_tuser  = 1'b0;
    logic                             s_axis_tlast  = 1'b0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [dnsqp_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                             m_axis_tuser;
    logic                             m_axis_tlast;

    int         fail_count;
    int         pending;
    int         char_count;
    int         finish_count;
    logic [3:0] status_seen;

    int   bytes_sent = 0;
    logic calm;

    // The sender inserts no gaps and the output side adds no random stalls in this stretch.
    assign calm = (bytes_sent >= 250) && (bytes_sent < 500);

    always #1 i_clk = ~i_clk;

    dns_query_name_parser_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    dns_query_name_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_s_axis_tlast  (s_axis_tlast),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tuser  (m_axis_tuser),
        .i_m_axis_tlast  (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_char_count    (char_count),
        .o_finish_count  (finish_count),
        .o_status_seen   (status_seen)
    );

    task automatic send_byte(input logic [7:0] b, input logic first, input logic final_byte);
        while (!calm && $urandom_range(99) < 33) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= first;
        s_axis_tlast  <= final_byte;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        bytes_sent++;
    endtask

    task automatic send_packet(input t_pkt_kind kind);
        t_in_byte pkt[$];
        int       n_labels;
        int       len;
        int       pick;
        int       cut;
        for (int i = 0; i < int'(dnsqp_pkg::HEADER_BYTES); i++) begin
            pkt.push_back('{data: 8'($urandom), pkt_first: 1'b0, pkt_end: 1'b0});
        end
        n_labels = (kind == PKT_OVERFLOW) ? 7 : $urandom_range(0, 4);
        for (int l = 0; l < n_labels; l++) begin
            pick = $urandom_range(99);
            if (kind == PKT_OVERFLOW) begin
                len = $urandom_range(40, int'(dnsqp_pkg::MAX_LABEL));
            end else if (pick < 85) begin
                len = $urandom_range(1, 8);
            end else if (pick < 95) begin
                len = $urandom_range(9, int'(dnsqp_pkg::MAX_LABEL) - 1);
            end else begin
                len = int'(dnsqp_pkg::MAX_LABEL);
            end
            pkt.push_back('{data: 8'(len), pkt_first: 1'b0, pkt_end: 1'b0});
            repeat (len) begin
                pkt.push_back('{data: 8'($urandom), pkt_first: 1'b0, pkt_end: 1'b0});
            end
        end
        // The name ends on a zero length or, less often, on an overlong one.
        len = ($urandom_range(3) == 0) ?
              $urandom_range(int'(dnsqp_pkg::MAX_LABEL) + 1, 255) : 0;
        pkt.push_back('{data: 8'(len), pkt_first: 1'b0, pkt_end: 1'b0});
        repeat (2 + $urandom_range(0, 2)) begin
            pkt.push_back('{data: 8'($urandom), pkt_first: 1'b0, pkt_end: 1'b0});
        end
        pkt[0].pkt_first = 1'b1;
        if (kind == PKT_EARLY_END || kind == PKT_ABANDON) begin
            cut = $urandom_range(0, pkt.size() - 1);
            while (pkt.size() > cut + 1) begin
                void'(pkt.pop_back());
            end
        end
        if (kind != PKT_ABANDON) begin
            pkt[pkt.size() - 1].pkt_end = 1'b1;
        end
        foreach (pkt[i]) begin
            send_byte(pkt[i].data, pkt[i].pkt_first, pkt[i].pkt_end);
        end
    endtask

    initial begin
        int        pick;
        t_pkt_kind kind;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Bytes outside a packet, then a packet with a zero character, a dot and an
        // overlong length, then a packet that ends on its start byte.
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'h00, 1'b1, 1'b0);
        for (int i = 1; i < int'(dnsqp_pkg::HEADER_BYTES); i++) begin
            send_byte((i % 2 == 0) ? 8'h00 : 8'hFF, 1'b0, 1'b0);
        end
        send_byte(8'd1, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(dnsqp_pkg::MAX_LABEL + 8'd1, 1'b0, 1'b0);
        send_byte(8'hA5, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'h5A, 1'b1, 1'b1);

        while (bytes_sent < 1200) begin
            if ($urandom_range(99) < 20) begin
                repeat ($urandom_range(1, 3)) begin
                    send_byte(8'($urandom), 1'b0, 1'($urandom));
                end
            end
            pick = $urandom_range(99);
            if (pick < 62) begin
                kind = PKT_CLEAN;
            end else if (pick < 80) begin
                kind = PKT_EARLY_END;
            end else if (pick < 92) begin
                kind = PKT_ABANDON;
            end else begin
                kind = PKT_OVERFLOW;
            end
            send_packet(kind);
        end
        s_axis_tvalid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        $display("Sent %0d packet bytes; checked %0d name characters and %0d finished parses.",
                 bytes_sent, char_count, finish_count);
        $display("Finish statuses seen (bit per status, overflow down to ok): %b", status_seen);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Output side: random stalls, none of them in the calm stretch, and one long hold-off,
    // which begins inside the calm stretch, while the sender keeps offering bytes.
    initial begin
        int   hold_left;
        logic hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (!hold_done && bytes_sent >= 400) begin
                hold_done = 1'b1;
                hold_left = 199;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm || ($urandom_range(99) >= 33);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results still expected.", pending);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
